[src/nnt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared constants and types of the nearest-neighbor tour builder.
// ----------------------------------------------------------------------------
package nnt_pkg;

    // Default sizes of the city store
    localparam int MAX_CITIES_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths of the stream payloads
    localparam int CITY_IDX_W  = 6;
    localparam int FIELD_XY_W  = 16;
    localparam int COUNT_W     = 7;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;

    // Reset value of the city count register
    localparam logic [COUNT_W-1:0] CITY_COUNT_RST = 7'd64;

    // Item kinds carried on s_tuser
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // Tag that travels beside a candidate through the distance pipeline
    typedef struct packed {
        logic                  valid;
        logic [CITY_IDX_W-1:0] idx;
    } cand_tag_t;

endpackage

[src/nnt_city_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt_city_mem
// City coordinate store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nnt_city_mem #(
    parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
    parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_CITIES)-1:0] wr_addr,
    input  logic [COORD_BITS-1:0]         wr_x,
    input  logic [COORD_BITS-1:0]         wr_y,
    input  logic [$clog2(MAX_CITIES)-1:0] rd_addr,
    output logic [COORD_BITS-1:0]         rd_x,
    output logic [COORD_BITS-1:0]         rd_y
);

    logic [2*COORD_BITS-1:0] mem [MAX_CITIES];
    logic [2*COORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_y, wr_x};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_x = rd_data_reg[COORD_BITS-1:0];
    assign rd_y = rd_data_reg[2*COORD_BITS-1:COORD_BITS];

endmodule

[src/nnt_dist_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt_dist_unit
// Pipelined squared-distance unit: absolute difference, square, sum.
// ----------------------------------------------------------------------------
module nnt_dist_unit #(
    parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  nnt_pkg::cand_tag_t     tag_in,
    input  logic [COORD_BITS-1:0]  cand_x,
    input  logic [COORD_BITS-1:0]  cand_y,
    input  logic [COORD_BITS-1:0]  ref_x,
    input  logic [COORD_BITS-1:0]  ref_y,
    output nnt_pkg::cand_tag_t     tag_out,
    output logic [2*COORD_BITS:0]  dist_sq,
    output logic [COORD_BITS-1:0]  out_x,
    output logic [COORD_BITS-1:0]  out_y
);

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 1;

    nnt_pkg::cand_tag_t    tag1_reg, tag2_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic [COORD_BITS-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [COORD_BITS-1:0] dx_next, dy_next;

    always_comb
    begin
        dx_next = (cand_x >= ref_x) ? (cand_x - ref_x) : (ref_x - cand_x);
        dy_next = (cand_y >= ref_y) ? (cand_y - ref_y) : (ref_y - cand_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        x1_reg  <= cand_x;
        y1_reg  <= cand_y;
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        x2_reg  <= x1_reg;
        y2_reg  <= y1_reg;
    end

    assign tag_out = tag2_reg;
    assign dist_sq = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    assign out_x   = x2_reg;
    assign out_y   = y2_reg;

endmodule

[src/nearest_neighbor_tour_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_builder
// Greedy nearest-neighbor tour over a loaded set of cities.
// ----------------------------------------------------------------------------
// A load transaction leaves the block idle, so the next item may follow at once.
// A run scans one candidate per cycle through the shared distance unit: after
// emitting the start city it reads every candidate, drains the pipeline and
// emits the nearest unvisited city, city by city. Output back-pressure stalls
// the emit step. No new item is taken during a run.
// Reset: async active low; city count goes to 64, visited marks clear, the
// coordinate store stays undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour_builder #(
    parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
    parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration: city_count
    input  logic                            cfg_wen,
    input  logic [nnt_pkg::COUNT_W-1:0]     cfg_wdata,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] city_index, [21:6] coord_x, [37:22] coord_y, [39:38] zero
    input  logic [nnt_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] kind
    input  logic                            s_tuser,
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] tour_position, [11:6] tour_city, [15:12] zero
    output logic [nnt_pkg::M_TDATA_W-1:0]   m_tdata,
    // last_of_tour
    output logic                            m_tlast
);

    localparam int ADDR_W       = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int DIST_W       = 2 * COORD_BITS + 1;
    localparam int IDX_W        = nnt_pkg::CITY_IDX_W;
    localparam int CNT_W        = nnt_pkg::COUNT_W;
    localparam int DRAIN_CYCLES = 3;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_FETCH   = 6'b000010,
        ST_LOADCUR = 6'b000100,
        ST_EMIT    = 6'b001000,
        ST_SCAN    = 6'b010000,
        ST_DRAIN   = 6'b100000
    } state_t;

    // Input fields
    logic [IDX_W-1:0]                in_idx;
    logic [nnt_pkg::FIELD_XY_W-1:0]  in_x, in_y;

    assign in_idx = s_tdata[5:0];
    assign in_x   = s_tdata[21:6];
    assign in_y   = s_tdata[37:22];

    // Control registers
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        city_count_reg;
    logic [MAX_CITIES-1:0]   visited_reg, visited_next;
    logic [ADDR_W-1:0]       cur_reg, cur_next;
    logic [ADDR_W-1:0]       last_reg, last_next;
    logic [ADDR_W-1:0]       pos_reg, pos_next;
    logic [ADDR_W-1:0]       j_reg, j_next;
    logic [1:0]              drain_reg, drain_next;
    logic                    found_reg, found_next;
    nnt_pkg::cand_tag_t      tag_d1_reg, tag_d1_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload registers
    logic [COORD_BITS-1:0]   cur_x_reg, cur_y_reg;
    logic [COORD_BITS-1:0]   best_x_reg, best_y_reg;
    logic [DIST_W-1:0]       best_d_reg;
    logic [ADDR_W-1:0]       best_idx_reg;
    logic [ADDR_W-1:0]       out_pos_reg, out_city_reg;
    logic                    out_last_reg;

    // Datapath wires
    logic                    in_fire, load_fire, run_fire, emit_fire, best_upd;
    logic [CNT_W-1:0]        lim;
    logic [ADDR_W-1:0]       rd_addr;
    logic [COORD_BITS-1:0]   rd_x, rd_y;
    nnt_pkg::cand_tag_t      tag_out;
    logic [DIST_W-1:0]       dist_sq;
    logic [COORD_BITS-1:0]   cand_x, cand_y;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (s_tuser == nnt_pkg::KIND_LOAD)
                       && ({1'b0, in_idx} < CNT_W'(MAX_CITIES));
    assign run_fire  = in_fire && (s_tuser == nnt_pkg::KIND_RUN);
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    // Clamp the count into 2..MAX_CITIES
    always_comb
    begin
        if (city_count_reg < CNT_W'(2))
        begin
            lim = CNT_W'(2);
        end
        else if (city_count_reg > CNT_W'(MAX_CITIES))
        begin
            lim = CNT_W'(MAX_CITIES);
        end
        else
        begin
            lim = city_count_reg;
        end
    end

    // Read the current city while fetching the start, else the scan candidate
    assign rd_addr = (state_reg == ST_FETCH) ? cur_reg : j_reg;

    nnt_city_mem #(
        .MAX_CITIES (MAX_CITIES),
        .COORD_BITS (COORD_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (load_fire),
        .wr_addr (in_idx[ADDR_W-1:0]),
        .wr_x    (COORD_BITS'(in_x)),
        .wr_y    (COORD_BITS'(in_y)),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    nnt_dist_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_d1_reg),
        .cand_x  (rd_x),
        .cand_y  (rd_y),
        .ref_x   (cur_x_reg),
        .ref_y   (cur_y_reg),
        .tag_out (tag_out),
        .dist_sq (dist_sq),
        .out_x   (cand_x),
        .out_y   (cand_y)
    );

    // Keep the first strictly closer candidate; scan order breaks ties low
    assign best_upd = tag_out.valid && (!found_reg || (dist_sq < best_d_reg));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        visited_next   = visited_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        drain_next     = drain_reg;
        found_next     = found_reg || best_upd;
        tag_d1_next    = '0;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (run_fire)
                begin
                    last_next    = ADDR_W'(lim - CNT_W'(1));
                    if ({1'b0, in_idx} >= lim)
                    begin
                        cur_next = ADDR_W'(lim - CNT_W'(1));
                    end
                    else
                    begin
                        cur_next = in_idx[ADDR_W-1:0];
                    end
                    visited_next           = '0;
                    visited_next[cur_next] = 1'b1;
                    pos_next               = '0;
                    state_next             = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOADCUR;
            end
            ST_LOADCUR:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    if (pos_reg == last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + ADDR_W'(1);
                        j_next     = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                tag_d1_next.valid = !visited_reg[j_reg];
                tag_d1_next.idx   = IDX_W'(j_reg);
                if (j_reg == last_reg)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // Advance once the last candidate has reached the pipeline output
                if (drain_reg == 2'(DRAIN_CYCLES - 1))
                begin
                    cur_next = best_upd ? tag_out.idx[ADDR_W-1:0] : best_idx_reg;
                    visited_next[cur_next] = 1'b1;
                    state_next             = ST_EMIT;
                end
                else
                begin
                    drain_next = drain_reg + 2'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            city_count_reg <= nnt_pkg::CITY_COUNT_RST;
            visited_reg    <= '0;
            cur_reg        <= '0;
            last_reg       <= '0;
            pos_reg        <= '0;
            j_reg          <= '0;
            drain_reg      <= '0;
            found_reg      <= 1'b0;
            tag_d1_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wen)
            begin
                city_count_reg <= cfg_wdata;
            end
            visited_reg    <= visited_next;
            cur_reg        <= cur_next;
            last_reg       <= last_next;
            pos_reg        <= pos_next;
            j_reg          <= j_next;
            drain_reg      <= drain_next;
            found_reg      <= found_next;
            tag_d1_reg     <= tag_d1_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload: reference coordinates, running best, output transaction
    always_ff @(posedge clk)
    begin
        if (best_upd)
        begin
            best_d_reg   <= dist_sq;
            best_idx_reg <= tag_out.idx[ADDR_W-1:0];
            best_x_reg   <= cand_x;
            best_y_reg   <= cand_y;
        end
        if (state_reg == ST_LOADCUR)
        begin
            cur_x_reg <= rd_x;
            cur_y_reg <= rd_y;
        end
        else if ((state_reg == ST_DRAIN) && (drain_reg == 2'(DRAIN_CYCLES - 1)))
        begin
            cur_x_reg <= best_upd ? cand_x : best_x_reg;
            cur_y_reg <= best_upd ? cand_y : best_y_reg;
        end
        if (emit_fire)
        begin
            out_pos_reg  <= pos_reg;
            out_city_reg <= cur_reg;
            out_last_reg <= (pos_reg == last_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, IDX_W'(out_city_reg), IDX_W'(out_pos_reg)};

endmodule

[test/nearest_neighbor_tour_builder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_builder_tb
// Self-checking bench for the greedy nearest-neighbor tour builder. A queue
// of city loads and tour runs feeds a bursty stream driver; every accepted
// run is expanded by an in-bench tour predictor into the expected sequence of
// (position, city, last) steps, and a monitor checks the output stream
// against them while the receiver stalls on its own random pattern.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour_builder_tb;

    localparam int CITY_SLOTS   = nnt_pkg::MAX_CITIES_DEF;
    localparam int IDX_W        = nnt_pkg::CITY_IDX_W;
    localparam int XY_W         = nnt_pkg::FIELD_XY_W;
    localparam int CNT_W        = nnt_pkg::COUNT_W;
    localparam int X_LSB        = IDX_W;
    localparam int Y_LSB        = IDX_W + XY_W;
    // Settle pause after the streams drain; give the block ample room.
    localparam int SETTLE_CYCLES = 16;
    // One long output hold-off, so the run stalls and the input backs up.
    localparam int HOLD_CYCLES   = 600;
    // Longest quiet stretch of a correct run: the hold-off, plus one scan step
    // of a 64-city tour, a receiver stall, the settle pause and a register
    // write. Allow several times that.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 110;
    localparam int PRINT_LIMIT    = 40;

    typedef struct {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [XY_W-1:0]  x;
        logic [XY_W-1:0]  y;
    } city_item_t;

    typedef struct {
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] city;
        logic             last;
    } tour_step_t;

    typedef enum int {COORD_FULL, COORD_NARROW, COORD_EXTREME} coord_mode_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          cfg_wen   = 1'b0;
    logic [CNT_W-1:0]              cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [nnt_pkg::S_TDATA_W-1:0] s_tdata   = '0;   // [5:0] city_index, [21:6] coord_x,
                                                     // [37:22] coord_y, [39:38] zero
    logic                          s_tuser   = nnt_pkg::KIND_LOAD; // [0] kind
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [nnt_pkg::M_TDATA_W-1:0] m_tdata;          // [5:0] tour_position, [11:6] tour_city,
                                                     // [15:12] zero
    logic                          m_tlast;

    // Stimulus and prediction state
    city_item_t            city_items [$];
    tour_step_t            tour_expect [$];
    logic [XY_W-1:0]       x_mem [CITY_SLOTS];
    logic [XY_W-1:0]       y_mem [CITY_SLOTS];
    logic [CNT_W-1:0]      count_reg = nnt_pkg::CITY_COUNT_RST;
    bit                    slot_loaded [CITY_SLOTS];
    coord_mode_t           coord_mode = COORD_FULL;
    int                    items_queued = 0;
    int                    mismatch_count = 0;
    bit                    hold_req = 1'b0;

    // Driver and receiver pacing
    int                    burst_left;
    int                    gap_left;
    int                    hold_left;
    bit                    hold_done;
    int                    stall_left;
    logic [15:0]           stall_bits;
    int                    quiet_cycles = 0;

    nearest_neighbor_tour_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Tour predictor
    // ------------------------------------------------------------------------

    // Clamp the register value to the number of cities a run really visits.
    function automatic int used_count(input logic [CNT_W-1:0] value);
        if (value < 2)
            return 2;
        if (value > CITY_SLOTS)
            return CITY_SLOTS;
        return value;
    endfunction

    // Store a loaded city, or expand a run into its expected tour steps.
    task automatic predict_tour_steps(input logic kind, input logic [IDX_W-1:0] idx,
                                      input logic [XY_W-1:0] x,
                                      input logic [XY_W-1:0] y);
        int              used;
        int              here;
        int              best;
        int              step;
        int              j;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned d;
        longint unsigned best_d;
        bit              visited [CITY_SLOTS];
        tour_step_t      st;
        if (kind == nnt_pkg::KIND_LOAD)
        begin
            x_mem[idx] = x;
            y_mem[idx] = y;
        end
        else
        begin
            used = used_count(count_reg);
            // A start at or beyond the count falls back to the last city.
            here = (idx >= used) ? used - 1 : idx;
            foreach (visited[k])
                visited[k] = 1'b0;
            visited[here] = 1'b1;
            for (step = 0; step < used; step++)
            begin
                if (step > 0)
                begin
                    best   = -1;
                    best_d = 0;
                    // Strict less-than keeps the lowest index on a tie.
                    for (j = 0; j < used; j++)
                    begin
                        if (!visited[j])
                        begin
                            dx = (x_mem[here] >= x_mem[j]) ? x_mem[here] - x_mem[j]
                                                           : x_mem[j] - x_mem[here];
                            dy = (y_mem[here] >= y_mem[j]) ? y_mem[here] - y_mem[j]
                                                           : y_mem[j] - y_mem[here];
                            d  = dx * dx + dy * dy;
                            if (best < 0 || d < best_d)
                            begin
                                best   = j;
                                best_d = d;
                            end
                        end
                    end
                    visited[best] = 1'b1;
                    here = best;
                end
                st.pos  = IDX_W'(step);
                st.city = IDX_W'(here);
                st.last = (step == used - 1);
                tour_expect.push_back(st);
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [XY_W-1:0] rand_coord();
        case (coord_mode)
            COORD_NARROW:  return XY_W'($urandom_range(0, 3));
            COORD_EXTREME: return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default:       return XY_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_load(input int idx, input logic [XY_W-1:0] x,
                              input logic [XY_W-1:0] y);
        city_item_t it;
        it.kind = nnt_pkg::KIND_LOAD;
        it.idx  = IDX_W'(idx);
        it.x    = x;
        it.y    = y;
        city_items.push_back(it);
        slot_loaded[idx] = 1'b1;
        items_queued++;
    endtask

    // Load any slot the run would read that was never written, then queue the run.
    task automatic queue_run(input int start);
        city_item_t it;
        for (int s = 0; s < used_count(count_reg); s++)
        begin
            if (!slot_loaded[s])
                queue_load(s, rand_coord(), rand_coord());
        end
        it.kind = nnt_pkg::KIND_RUN;
        it.idx  = IDX_W'(start);
        it.x    = XY_W'($urandom);
        it.y    = XY_W'($urandom);
        city_items.push_back(it);
        items_queued++;
    endtask

    // Wait until all queued transactions went in and all tour steps came out.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (city_items.size() != 0 || s_tvalid || tour_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_city_count(input logic [CNT_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        count_reg = value;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps in between
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        city_item_t next_item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= nnt_pkg::KIND_LOAD;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            // Predict from what was on the bus when the transaction completed.
            if (s_tvalid && s_tready)
            begin
                predict_tour_steps(s_tuser, s_tdata[IDX_W-1:0],
                                   s_tdata[X_LSB +: XY_W],
                                   s_tdata[Y_LSB +: XY_W]);
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    // Leave some bursts back to back with no gap at all.
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            // Hold the current item until taken; otherwise advance or idle.
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (city_items.size() != 0)
                begin
                    next_item = city_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_item.kind;
                    s_tdata  <= {2'b00, next_item.y, next_item.x, next_item.idx};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: own stall pattern, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left  = 0;
            hold_done  = 1'b0;
            stall_left = 0;
            stall_bits = '1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            // Draw a fresh 16-bit stall pattern; about one in four never stalls.
            if (stall_left == 0)
            begin
                stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                stall_left = 16;
            end
            m_tready <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[15:1]};
            stall_left--;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each tour step against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_steps
        tour_step_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tour_expect.size() == 0)
            begin
                report_mismatch($sformatf("unexpected step pos %0d city %0d last %0b",
                                          m_tdata[5:0], m_tdata[11:6], m_tlast));
            end
            else
            begin
                want = tour_expect.pop_front();
                if (m_tdata[5:0] !== want.pos)
                    report_mismatch($sformatf("tour_position %0d, want %0d",
                                              m_tdata[5:0], want.pos));
                if (m_tdata[11:6] !== want.city)
                    report_mismatch($sformatf("tour_city %0d at pos %0d, want %0d",
                                              m_tdata[11:6], want.pos, want.city));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_of_tour %0b at pos %0d, want %0b",
                                              m_tlast, want.pos, want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d steps still expected", $realtime, tour_expect.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed cases, pressure phase, random phases
    // ------------------------------------------------------------------------
    initial
    begin : run_sequence
        int random_items;
        int phase_len;
        int used;
        bit ran;
        logic [CNT_W-1:0] next_count;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Two cities at opposite corners; the out-of-range start clamps to 1.
        set_city_count(7'd2);
        queue_load(0, 16'h0000, 16'h0000);
        queue_load(1, 16'hFFFF, 16'hFFFF);
        queue_run(0);
        queue_run(63);

        // Counts below the minimum are used as two.
        set_city_count(7'd0);
        queue_run(1);
        set_city_count(7'd1);
        queue_run(0);

        // Equal distances: 1 and 2 sit on either side of 0, 3 on top of 0.
        set_city_count(7'd4);
        queue_load(0, 16'd100, 16'd100);
        queue_load(1, 16'd110, 16'd100);
        queue_load(2, 16'd90, 16'd100);
        queue_load(3, 16'd100, 16'd100);
        queue_run(0);
        queue_run(3);
        queue_run(2);

        // Top slot and mixed extreme coordinates; start beyond count clamps.
        set_city_count(7'd3);
        queue_load(63, 16'hFFFF, 16'h0000);
        queue_load(2, 16'h0000, 16'hFFFF);
        queue_run(5);

        // Pressure: receiver holds off while runs and loads keep coming.
        set_city_count(7'd6);
        hold_req = 1'b1;
        for (int k = 0; k < 3; k++)
            queue_load($urandom_range(0, 5), rand_coord(), rand_coord());
        queue_run($urandom_range(0, 63));
        for (int k = 0; k < 3; k++)
            queue_load($urandom_range(0, 5), rand_coord(), rand_coord());
        queue_run($urandom_range(0, 63));

        // Random phases: new count, then loads and runs with random content.
        random_items = items_queued;
        for (int phase = 0; items_queued - random_items < RANDOM_ITEMS; phase++)
        begin
            case (phase)
                0: next_count = 7'd127;
                3: next_count = 7'd64;
                default:
                begin
                    case ($urandom_range(0, 19))
                        0:       next_count = CNT_W'($urandom_range(0, 1));
                        1:       next_count = 7'd64;
                        2:       next_count = CNT_W'($urandom_range(65, 127));
                        3, 4, 5: next_count = CNT_W'($urandom_range(11, 24));
                        default: next_count = CNT_W'($urandom_range(2, 10));
                    endcase
                end
            endcase
            set_city_count(next_count);
            coord_mode = coord_mode_t'($urandom_range(0, 2));
            used       = used_count(count_reg);
            phase_len  = $urandom_range(3, 10);
            ran        = 1'b0;
            for (int k = 0; k < phase_len; k++)
            begin
                // Keep long tours to one run per phase.
                if ($urandom_range(0, 3) == 0 && (used <= 16 || !ran))
                begin
                    queue_run($urandom_range(0, 63));
                    ran = 1'b1;
                end
                else if ($urandom_range(0, 9) < 7)
                begin
                    queue_load($urandom_range(0, used - 1), rand_coord(), rand_coord());
                end
                else
                begin
                    queue_load($urandom_range(0, CITY_SLOTS - 1), rand_coord(), rand_coord());
                end
            end
            // Close a phase with a run if none ran, so every phase builds a tour.
            if (!ran || (used <= 16 && $urandom_range(0, 1) == 0))
                queue_run($urandom_range(0, 63));
        end

        // Drain everything, then let the block settle before the verdict.
        wait_idle();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
src/nnt_pkg.sv
src/nnt_city_mem.sv
src/nnt_dist_unit.sv
src/nearest_neighbor_tour_builder.sv
test/nearest_neighbor_tour_builder_tb.sv
